// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the decimal text converter.
// Included by each module that checks itself; depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define SITDA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sitda assertion failed");
// expression must never be true outside reset
`define SITDA_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("sitda forbidden condition seen");
`else
`define SITDA_ASSERT(label, clk, rst, prop)
`define SITDA_NEVER(label, clk, rst, expr)
`endif
`endif

// ----- src/sitda_pkg.sv -----
// Constants, types and helper functions of the decimal text converter.
// Stand-alone package; used by signed_int_to_decimal_ascii.
package sitda_pkg;

   // input width and the packed bus width that carries it
   localparam int VALUE_BITS     = 32;
   localparam int REQ_W          = ((VALUE_BITS + 7) / 8) * 8;

   // double-dabble: bits consumed per pipeline stage
   localparam int BITS_PER_STAGE = 4;
   localparam int DD_STAGES      = (VALUE_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
   localparam int MAG_W          = DD_STAGES * BITS_PER_STAGE;

   // decimal digits for an MAG_W-bit magnitude (1233/4096 ~ log10(2))
   localparam int DIGITS         = (MAG_W * 1233) / 4096 + 1;
   localparam int IDX_W          = $clog2(DIGITS);

   localparam int CHAR_W         = 8;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

   typedef logic [DIGITS-1:0][3:0] bcd_type;

   typedef struct packed {
      logic             valid;
      logic             neg;
      logic [MAG_W-1:0] mag;
      bcd_type          bcd;
   } stage_type;

   // one double-dabble step: add 3 to digits of 5 and up, then shift in a bit
   function automatic bcd_type dd_step(bcd_type bcd, logic bit_in);
      bcd_type               adj;
      logic [DIGITS*4-1:0]   flat;
      adj = bcd;
      for (int i = 0; i < DIGITS; i++) begin
         if (adj[i] >= 4'd5) begin
            adj[i] = adj[i] + 4'd3;
         end
      end
      flat = adj;
      flat = {flat[DIGITS*4-2:0], bit_in};
      return flat;
   endfunction

   // position of the most significant non-zero digit, zero when all are zero
   function automatic logic [IDX_W-1:0] lead_index(bcd_type bcd);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd[i] != 4'd0) begin
            idx = IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ----- src/signed_int_to_decimal_ascii.sv -----
// Signed integer to decimal ASCII text converter. Each accepted item is one
// two's complement integer; the block sends its decimal text, most
// significant character first, a '-' first for negative values, no leading
// zeros, and tlast on the final character. The most negative value is exact.
// An item is registered with its sign and magnitude, then passes DD_STAGES (8)
// double-dabble stages of four bits each before its first character shows.
// The character serialiser then sends one character a cycle while rsp_tready
// is high: a number is 1 to 11 characters (sign plus digits), and that
// serialiser sets the sustained rate. A new item is loaded into the
// serialiser in the same cycle that the previous item's last character is
// taken, so runs follow back to back.
// Depends on sitda_pkg and assert_macros.svh.
`include "assert_macros.svh"

module signed_int_to_decimal_ascii
   import sitda_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // input item
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,   // [VALUE_BITS-1:0] value, rest zero
   // result item
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [CHAR_W-1:0] rsp_tdata,   // [7:0] character
   output logic              rsp_tlast    // last_char
);

   stage_type                stage_ff [DD_STAGES+1];
   stage_type                stage_in [DD_STAGES+1];
   stage_type                cur;
   stage_type                last_stage;

   logic                     busy_ff,   busy_in;
   logic                     sign_ff,   sign_in;
   logic [IDX_W-1:0]         idx_ff,    idx_in;
   bcd_type                  digits_ff, digits_in;

   logic [VALUE_BITS-1:0]    value;
   logic [VALUE_BITS-1:0]    mag_full;
   logic                     take;
   logic                     done_take;
   logic                     ser_load;
   logic                     pipe_en;

   assign last_stage = stage_ff[DD_STAGES];

   // serialiser handshake and pipeline advance
   assign take       = rsp_tvalid && rsp_tready;
   assign done_take  = take && !sign_ff && (idx_ff == '0);
   assign ser_load   = last_stage.valid && (!busy_ff || done_take);
   assign pipe_en    = !last_stage.valid || ser_load;
   assign req_tready = pipe_en;

   // entry: sign and magnitude, no whole negation beyond one adder
   assign value    = req_tdata[VALUE_BITS-1:0];
   assign mag_full = value[VALUE_BITS-1] ? (~value + 1'b1) : value;

   // next values of all pipeline stages
   always_comb begin
      stage_in[0].valid = req_tvalid;
      stage_in[0].neg   = value[VALUE_BITS-1];
      stage_in[0].mag   = MAG_W'(mag_full);
      stage_in[0].bcd   = '0;
      for (int k = 1; k <= DD_STAGES; k++) begin
         cur = stage_ff[k-1];
         for (int b = 0; b < BITS_PER_STAGE; b++) begin
            cur.bcd = dd_step(cur.bcd, cur.mag[MAG_W-1]);
            cur.mag = {cur.mag[MAG_W-2:0], 1'b0};
         end
         stage_in[k] = cur;
      end
   end

   // pipeline registers, one enable for the whole chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DD_STAGES; k++) begin
            stage_ff[k].valid <= 1'b0;
         end
      end else if (pipe_en) begin
         for (int k = 0; k <= DD_STAGES; k++) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   // serialiser next state
   always_comb begin
      busy_in   = busy_ff;
      sign_in   = sign_ff;
      idx_in    = idx_ff;
      digits_in = digits_ff;
      if (ser_load) begin
         busy_in   = 1'b1;
         sign_in   = last_stage.neg;
         idx_in    = lead_index(last_stage.bcd);
         digits_in = last_stage.bcd;
      end else if (take) begin
         if (sign_ff) begin
            sign_in = 1'b0;
         end else if (idx_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff - 1'b1;
         end
      end
   end

   // serialiser registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      sign_ff   <= sign_in;
      idx_ff    <= idx_in;
      digits_ff <= digits_in;
   end

   // character output
   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = sign_ff ? CHAR_MINUS : (CHAR_ZERO + {4'd0, digits_ff[idx_ff]});
   assign rsp_tlast  = !sign_ff && (idx_ff == '0);

   // checks
   `SITDA_ASSERT(a_digit_bcd, clock, reset,
                 (rsp_tvalid && !sign_ff) |-> (digits_ff[idx_ff] <= 4'd9))
   `SITDA_ASSERT(a_minus_first, clock, reset,
                 (ser_load && last_stage.neg) |=> (rsp_tvalid && rsp_tdata == CHAR_MINUS))
   `SITDA_ASSERT(a_stall_holds, clock, reset,
                 !pipe_en |=> last_stage.valid)
   `SITDA_NEVER(a_load_over_run, clock, reset,
                ser_load && busy_ff && !done_take)

endmodule
